// ===== rtl/smfmd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smfmd_pkg: shared types and constants
// Operation codes, fault codes, the classified item passed from the front end
// to the execution unit, and the 16-bit saturation helpers.
// ----------------------------------------------------------------------------
package smfmd_pkg;

    localparam int FRAC_BITS_DEFAULT   = 14;
    localparam int QUEUE_DEPTH_DEFAULT = 2;
    localparam int DIV_W               = 32;

    localparam logic [1:0] CMD_MUL    = 2'd0;
    localparam logic [1:0] CMD_DIV    = 2'd1;
    localparam logic [1:0] CMD_MULDIV = 2'd2;

    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_HIGH = 2'd1;
    localparam logic [1:0] FAULT_LOW  = 2'd2;
    localparam logic [1:0] FAULT_DIV0 = 2'd3;

    localparam logic signed [15:0] SAT_HIGH = 16'sh7fff;
    localparam logic signed [15:0] SAT_LOW  = 16'sh8000;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_MULDIV,
        OP_CONST
    } op_t;

    typedef struct packed {
        op_t                op;
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] den;
        logic [1:0]         fault;
    } item_t;

    function automatic logic signed [15:0] clamp16(input logic signed [31:0] v);
        logic signed [15:0] r;
        if (v > 32'(SAT_HIGH)) begin
            r = SAT_HIGH;
        end else if (v < 32'(SAT_LOW)) begin
            r = SAT_LOW;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic [1:0] clamp_fault(input logic signed [31:0] v);
        logic [1:0] f;
        if (v > 32'(SAT_HIGH)) begin
            f = FAULT_HIGH;
        end else if (v < 32'(SAT_LOW)) begin
            f = FAULT_LOW;
        end else begin
            f = FAULT_NONE;
        end
        return f;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/smfmd_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smfmd_if: command and result channels
// Valid/ready channels carrying one command beat and one result beat.
// ----------------------------------------------------------------------------
interface smfmd_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic signed [31:0] operand_c;

    modport source(output valid, output cmd, output operand_a, output operand_b,
                   output operand_c, input ready);
    modport sink(input valid, input cmd, input operand_a, input operand_b,
                 input operand_c, output ready);
endinterface

interface smfmd_res_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] product;
    logic [1:0]         fault_code;

    modport source(output valid, output product, output fault_code, input ready);
    modport sink(input valid, input product, input fault_code, output ready);
endinterface
`default_nettype wire

// ===== rtl/smfmd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smfmd_front: command intake and classification
// Clamps the operands, detects zero divisors and records operand faults.
// ----------------------------------------------------------------------------
module smfmd_front (
    smfmd_cmd_if.sink         cmd_ch,
    output logic              push_valid,
    input  logic              push_ready,
    output smfmd_pkg::item_t  push_item
);

    logic signed [15:0] ta;
    logic signed [15:0] tb;
    logic signed [15:0] tc;
    logic [1:0]         fa;
    logic [1:0]         fb;
    logic [1:0]         fc;
    logic [1:0]         fab;

    assign ta  = smfmd_pkg::clamp16(cmd_ch.operand_a);
    assign tb  = smfmd_pkg::clamp16(cmd_ch.operand_b);
    assign tc  = smfmd_pkg::clamp16(cmd_ch.operand_c);
    assign fa  = smfmd_pkg::clamp_fault(cmd_ch.operand_a);
    assign fb  = smfmd_pkg::clamp_fault(cmd_ch.operand_b);
    assign fc  = smfmd_pkg::clamp_fault(cmd_ch.operand_c);
    assign fab = (fb != smfmd_pkg::FAULT_NONE) ? fb : fa;

    assign push_valid   = cmd_ch.valid;
    assign cmd_ch.ready = push_ready;

    always_comb
    begin
        push_item.a     = ta;
        push_item.b     = tb;
        push_item.den   = tb;
        push_item.op    = smfmd_pkg::OP_CONST;
        push_item.fault = smfmd_pkg::FAULT_NONE;
        case (cmd_ch.cmd)
            smfmd_pkg::CMD_MUL:
            begin
                push_item.op    = smfmd_pkg::OP_MUL;
                push_item.fault = fab;
            end
            smfmd_pkg::CMD_DIV:
            begin
                if (cmd_ch.operand_b == 32'sd0) begin
                    push_item.fault = smfmd_pkg::FAULT_DIV0;
                end else begin
                    push_item.op    = smfmd_pkg::OP_DIV;
                    push_item.fault = fab;
                end
            end
            smfmd_pkg::CMD_MULDIV:
            begin
                push_item.den = tc;
                if (cmd_ch.operand_c == 32'sd0) begin
                    push_item.fault = smfmd_pkg::FAULT_DIV0;
                end else begin
                    push_item.op    = smfmd_pkg::OP_MULDIV;
                    push_item.fault = (fc != smfmd_pkg::FAULT_NONE) ? fc : fab;
                end
            end
            default:
            begin
                push_item.op    = smfmd_pkg::OP_CONST;
                push_item.fault = smfmd_pkg::FAULT_NONE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/smfmd_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smfmd_queue: classified item queue
// A small FIFO that decouples the front end from the execution unit.
// ----------------------------------------------------------------------------
module smfmd_queue #(
    parameter int DEPTH = smfmd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  smfmd_pkg::item_t push_item,
    output logic             pop_valid,
    input  logic             pop_ready,
    output smfmd_pkg::item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    smfmd_pkg::item_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/smfmd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smfmd_back: execution unit
// Multiplies, divides one quotient bit per cycle, saturates the result and
// keeps the sticky fault status.
// ----------------------------------------------------------------------------
module smfmd_back #(
    parameter int FRAC_BITS = smfmd_pkg::FRAC_BITS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  smfmd_pkg::item_t pop_item,
    smfmd_res_if.source      res_ch
);

    localparam int CNT_W = $clog2(smfmd_pkg::DIV_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SETUP,
        S_DIV,
        S_FIN
    } state_t;

    state_t                          state_reg, state_next;
    smfmd_pkg::item_t                item_reg, item_next;
    logic signed [31:0]              prod_reg, prod_next;
    logic [smfmd_pkg::DIV_W-1:0]     num_reg, num_next;
    logic [smfmd_pkg::DIV_W-1:0]     quo_reg, quo_next;
    logic [15:0]                     rem_reg, rem_next;
    logic [15:0]                     den_reg, den_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic                            neg_reg, neg_next;
    logic [1:0]                      status_reg, status_next;
    logic                            out_valid_reg, out_valid_next;
    logic signed [15:0]              out_product_reg, out_product_next;
    logic [1:0]                      out_fault_reg, out_fault_next;

    logic [16:0]                     trial;
    logic                            qbit;
    logic signed [31:0]              r_full;
    logic signed [15:0]              r_val;
    logic [1:0]                      r_fault;
    logic [1:0]                      code;

    assign pop_ready         = (state_reg == S_IDLE);
    assign res_ch.valid      = out_valid_reg;
    assign res_ch.product    = out_product_reg;
    assign res_ch.fault_code = out_fault_reg;

    assign trial = {rem_reg, num_reg[smfmd_pkg::DIV_W-1]};
    assign qbit  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        case (item_reg.op)
            smfmd_pkg::OP_MUL:
            begin
                r_full = prod_reg >>> FRAC_BITS;
            end
            smfmd_pkg::OP_DIV, smfmd_pkg::OP_MULDIV:
            begin
                r_full = neg_reg ? -signed'(quo_reg) : signed'(quo_reg);
            end
            default:
            begin
                r_full = (item_reg.fault == smfmd_pkg::FAULT_DIV0) ? 32'(smfmd_pkg::SAT_HIGH)
                                                                   : 32'sd0;
            end
        endcase
        r_val   = smfmd_pkg::clamp16(r_full);
        r_fault = (item_reg.op == smfmd_pkg::OP_CONST) ? smfmd_pkg::FAULT_NONE
                                                       : smfmd_pkg::clamp_fault(r_full);
        code    = (r_fault != smfmd_pkg::FAULT_NONE) ? r_fault : item_reg.fault;
    end

    always_comb
    begin
        state_next       = state_reg;
        item_next        = item_reg;
        prod_next        = prod_reg;
        num_next         = num_reg;
        quo_next         = quo_reg;
        rem_next         = rem_reg;
        den_next         = den_reg;
        cnt_next         = cnt_reg;
        neg_next         = neg_reg;
        status_next      = status_reg;
        out_valid_next   = out_valid_reg && !res_ch.ready;
        out_product_next = out_product_reg;
        out_fault_next   = out_fault_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (pop_valid) begin
                    item_next  = pop_item;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (item_reg.op == smfmd_pkg::OP_DIV) begin
                    prod_next = 32'(item_reg.a) <<< FRAC_BITS;
                end else begin
                    prod_next = 32'(item_reg.a) * 32'(item_reg.b);
                end
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                num_next = prod_reg[31] ? 32'(-prod_reg) : 32'(prod_reg);
                den_next = item_reg.den[15] ? 16'(-item_reg.den) : 16'(item_reg.den);
                neg_next = prod_reg[31] ^ item_reg.den[15];
                rem_next = '0;
                quo_next = '0;
                cnt_next = CNT_W'(smfmd_pkg::DIV_W - 1);
                if (item_reg.op == smfmd_pkg::OP_DIV || item_reg.op == smfmd_pkg::OP_MULDIV)
                begin
                    state_next = S_DIV;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_DIV:
            begin
                rem_next = qbit ? 16'(trial - {1'b0, den_reg}) : trial[15:0];
                quo_next = {quo_reg[smfmd_pkg::DIV_W-2:0], qbit};
                num_next = {num_reg[smfmd_pkg::DIV_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || res_ch.ready) begin
                    if (code != smfmd_pkg::FAULT_NONE) begin
                        status_next = code;
                    end
                    out_valid_next   = 1'b1;
                    out_product_next = r_val;
                    out_fault_next   = (code != smfmd_pkg::FAULT_NONE) ? code : status_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            status_reg    <= smfmd_pkg::FAULT_NONE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg       <= state_next;
            status_reg      <= status_next;
            out_valid_reg   <= out_valid_next;
            item_reg        <= item_next;
            prod_reg        <= prod_next;
            num_reg         <= num_next;
            quo_reg         <= quo_next;
            rem_reg         <= rem_next;
            den_reg         <= den_next;
            cnt_reg         <= cnt_next;
            neg_reg         <= neg_next;
            out_product_reg <= out_product_next;
            out_fault_reg   <= out_fault_next;
        end
    end

`ifndef ASSERT_OFF
    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && cnt_reg == '0) |=> (state_reg == S_FIN))
        else $error("divider did not finish after the last quotient bit");

    a_status_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (status_reg != smfmd_pkg::FAULT_NONE) |=> (status_reg != smfmd_pkg::FAULT_NONE))
        else $error("fault status returned to none");

    a_beat_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result beat raised outside the finish state");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && (item_reg.op == smfmd_pkg::OP_DIV ||
         item_reg.op == smfmd_pkg::OP_MULDIV)) |-> (rem_reg < den_reg))
        else $error("division remainder not below divisor");

    a_fault_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (out_fault_reg == status_reg))
        else $error("reported fault code differs from status");
`endif

endmodule
`default_nettype wire

// ===== rtl/saturating_fixed_muldiv.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// saturating_fixed_muldiv: saturating 16-bit fixed-point multiply and divide
// Top level joining the front end, the item queue and the execution unit.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_ch carries one command beat: cmd (0 multiply, 1 divide, 2 multiply
//   then divide) and three 32-bit signed operands, clamped to 16 bits.
//   res_ch returns one result beat per command: the saturated product and
//   the sticky fault status after that command.
//   A multiply or a constant result (zero divisor, unused command) passes
//   the execution states S_MUL, S_SETUP and S_FIN before its result beat; a
//   divide or multiply-divide also passes S_DIV, where the 32-bit restoring
//   divider forms one quotient bit a cycle.
//   One command is executed at a time; the queue in front of the execution
//   unit accepts up to QUEUE_DEPTH further commands while one is being
//   worked on.
//   Reset clears the queue, the fault status and the result valid.
//   When the receiver stalls, the finished result is held in the output
//   register; the next command is computed and waits for that beat to go.
// ----------------------------------------------------------------------------
module saturating_fixed_muldiv #(
    parameter int FRAC_BITS   = smfmd_pkg::FRAC_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = smfmd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    smfmd_cmd_if.sink   cmd_ch,
    smfmd_res_if.source res_ch
);

    logic             push_valid;
    logic             push_ready;
    smfmd_pkg::item_t push_item;
    logic             pop_valid;
    logic             pop_ready;
    smfmd_pkg::item_t pop_item;

    smfmd_front u_front (
        .cmd_ch     (cmd_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    smfmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    smfmd_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .res_ch    (res_ch)
    );

endmodule
`default_nettype wire
